FILE: design/whsp_pkg.sv
// Package for the wheel speed tachometer: field widths, register indexes,
// reset values and the sequencer state type.
// Depends on nothing; imported by the channel interfaces and the top level.
package whsp_pkg;

   // fixed field widths
   localparam int SPEED_W    = 24;
   localparam int THR_W      = 10;
   localparam int PERIM_W    = 16;
   localparam int TMO_W      = 16;
   localparam int TIME_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // default parameter values
   localparam int DEF_SPEED_FRAC_BITS = 8;
   localparam int DEF_SAMPLE_BITS     = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_PERIMETER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_TIMEOUT    = 2'd2;

   // register reset values
   localparam logic [THR_W-1:0]   RST_PULSE_THRESHOLD = 10'd500;
   localparam logic [PERIM_W-1:0] RST_WHEEL_PERIMETER = 16'd2100;
   localparam logic [TMO_W-1:0]   RST_STOP_TIMEOUT    = 16'd2000;

   // saturated speed
   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE
   } whsp_state_type;

endpackage

FILE: design/whsp_channels.sv
// Valid/ready channel interfaces of the wheel speed tachometer: sample
// requests, speed responses and register writes.
// Depends on whsp_pkg for field widths.
interface whsp_req_if
   import whsp_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic [TIME_W-1:0]      now_ms;

   modport source (output valid, output sample, output now_ms, input ready);
   modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface whsp_rsp_if
   import whsp_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed_q8;
   logic               pulse_seen;
   logic               stopped;

   modport source (output valid, output speed_q8, output pulse_seen, output stopped,
                   input ready);
   modport sink   (input valid, input speed_q8, input pulse_seen, input stopped,
                   output ready);
endinterface

interface whsp_csr_if
   import whsp_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/wheel_speed_from_hall_pulses.sv
// Wheel speed from hall-sensor pulses: period-measuring tachometer top level.
// Depends on whsp_pkg and the channel interfaces in whsp_channels.sv.
//
// Each request beat carries one hall ADC sample and a millisecond timestamp;
// each one yields exactly one response beat with the held speed (m/s, fixed
// point with SPEED_FRAC_BITS fraction bits, saturated to 24 bits), a pulse
// flag and a stop-timeout flag. A sample that makes no speed update passes
// through the write state from acceptance until the block is ready again.
// A pulse that follows an earlier one with a nonzero interval runs a
// restoring divider that yields one quotient bit per cycle, then the write
// state. The response sits in an output register, so a stalled response
// does not hold back the next request while the result of that request has
// somewhere to wait. Register writes are always taken.
module wheel_speed_from_hall_pulses
   import whsp_pkg::*;
#(
   parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS,
   parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   whsp_req_if.sink   req_if,
   whsp_rsp_if.source rsp_if,
   whsp_csr_if.sink   csr_if
);

   localparam int NUM_W = PERIM_W + SPEED_FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

   // configuration registers
   logic [THR_W-1:0]   threshold_ff;
   logic [PERIM_W-1:0] perimeter_ff;
   logic [TMO_W-1:0]   timeout_ff;

   // tachometer state
   logic [TIME_W-1:0]  last_pulse_ff, last_pulse_in;
   logic               have_prior_ff, have_prior_in;
   logic               latched_ff, latched_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic               pend_pulse_ff, pend_pulse_in;
   logic               pend_stopped_ff, pend_stopped_in;

   // sequencer and divider
   whsp_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]   qn_ff, qn_in;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0]  div_ff, div_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0] rsp_speed_ff;
   logic               rsp_pulse_ff;
   logic               rsp_stopped_ff;

   // per-beat decode
   logic               req_fire;
   logic               out_free;
   logic               load_out;
   logic [TIME_W-1:0]  elapsed;
   logic               is_stopped;
   logic               is_below;
   logic               is_pulse;
   logic               need_div;

   // divider step
   logic [TIME_W:0]        trial;
   logic [TIME_W:0]        diff;
   logic                   take;
   logic [NUM_W+SPEED_W-1:0] quot_ext;
   logic [SPEED_W-1:0]     quot_sat;

   assign csr_if.ready = 1'b1;
   assign req_fire     = req_if.valid & req_if.ready;
   assign out_free     = ~rsp_valid_ff | rsp_if.ready;

   // decode the accepted sample against the held state
   assign elapsed    = req_if.now_ms - last_pulse_ff;
   assign is_stopped = elapsed > TIME_W'(timeout_ff);
   assign is_below   = CMP_W'(req_if.sample) < CMP_W'(threshold_ff);
   assign is_pulse   = is_below & ~latched_ff;
   assign need_div   = is_pulse & have_prior_ff & (elapsed != '0);

   // one restoring division step: shift in the next numerator bit, try subtract
   assign trial    = {rem_ff, qn_ff[NUM_W-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign take     = trial >= {1'b0, div_ff};
   assign quot_ext = {{SPEED_W{1'b0}}, qn_in};
   assign quot_sat = (quot_ext[NUM_W+SPEED_W-1:SPEED_W] != '0) ? SPEED_MAX
                                                               : quot_ext[SPEED_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = need_div ? ST_DIVIDE : ST_WRITE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_if.ready = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_if.ready = 1'b1;
         ST_DIVIDE: req_if.ready = 1'b0;
         ST_WRITE:  load_out     = out_free;
         default:   req_if.ready = 1'b0;
      endcase
   end

   // state and divider datapath
   always_comb begin
      last_pulse_in   = last_pulse_ff;
      have_prior_in   = have_prior_ff;
      latched_in      = latched_ff;
      speed_in        = speed_ff;
      pend_pulse_in   = pend_pulse_ff;
      pend_stopped_in = pend_stopped_ff;
      cnt_in          = cnt_ff;
      qn_in           = qn_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      if (req_fire) begin
         // clear on timeout, then update on a pulse
         pend_pulse_in   = is_pulse;
         pend_stopped_in = is_stopped;
         latched_in      = is_below;
         if (is_stopped) begin
            speed_in = '0;
         end
         if (is_pulse) begin
            last_pulse_in = req_if.now_ms;
            have_prior_in = 1'b1;
            if (have_prior_ff && elapsed == '0) begin
               speed_in = SPEED_MAX;
            end
         end
         // load the divider
         qn_in  = NUM_W'(perimeter_ff) << SPEED_FRAC_BITS;
         rem_in = '0;
         div_in = elapsed;
         cnt_in = CNT_W'(NUM_W - 1);
      end else if (state_ff == ST_DIVIDE) begin
         // advance one quotient bit
         qn_in  = {qn_ff[NUM_W-2:0], take};
         rem_in = take ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            speed_in = quot_sat;
         end
      end
   end

   // output beat: load when free, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_pulse_ff <= '0;
         have_prior_ff <= 1'b0;
         latched_ff    <= 1'b0;
         speed_ff      <= '0;
         threshold_ff  <= RST_PULSE_THRESHOLD;
         perimeter_ff  <= RST_WHEEL_PERIMETER;
         timeout_ff    <= RST_STOP_TIMEOUT;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_pulse_ff <= last_pulse_in;
         have_prior_ff <= have_prior_in;
         latched_ff    <= latched_in;
         speed_ff      <= speed_in;
         // register writes; an unknown index is dropped
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               REG_PULSE_THRESHOLD: threshold_ff <= csr_if.data[THR_W-1:0];
               REG_WHEEL_PERIMETER: perimeter_ff <= csr_if.data[PERIM_W-1:0];
               REG_STOP_TIMEOUT:    timeout_ff   <= csr_if.data[TMO_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_pulse_ff   <= pend_pulse_in;
      pend_stopped_ff <= pend_stopped_in;
      cnt_ff          <= cnt_in;
      qn_ff           <= qn_in;
      rem_ff          <= rem_in;
      div_ff          <= div_in;
      if (load_out) begin
         rsp_speed_ff   <= speed_ff;
         rsp_pulse_ff   <= pend_pulse_ff;
         rsp_stopped_ff <= pend_stopped_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.speed_q8   = rsp_speed_ff;
   assign rsp_if.pulse_seen = rsp_pulse_ff;
   assign rsp_if.stopped    = rsp_stopped_ff;

   // a timed-out beat without a pulse reports zero speed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stopped_ff && !rsp_pulse_ff |-> rsp_speed_ff == '0)
      else $error("stopped beat with nonzero speed");

   // a repeat pulse with a nonzero interval starts the divider
   assert property (@(posedge clock) disable iff (reset)
      req_fire && is_pulse && have_prior_ff && elapsed != '0 |=> state_ff == ST_DIVIDE)
      else $error("repeat pulse did not start the divider");

   // the partial remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < div_ff)
      else $error("divider remainder out of range");

   // an accepted beat always blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("request accepted on consecutive cycles");

endmodule
